// File: rtl/wpp_pkg.sv
package wpp_pkg;

  // Header layout: byte count and the offsets of the last byte of each field
  localparam int unsigned HEADER_LEN = 44;
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_FORMAT   = 6'd21;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_SIZE     = 6'd43;

  // Chunk tags as seen little-endian in a 32-bit word
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] DEPTH_8    = 16'd8;
  localparam logic [15:0] DEPTH_16   = 16'd16;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [15:0] DEPTH_32   = 16'd32;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_RIFF       = 3'd0,
    ERR_WAVE       = 3'd1,
    ERR_FMT        = 3'd2,
    ERR_FORMAT     = 3'd3,
    ERR_DATA       = 3'd4,
    ERR_INCOMPLETE = 3'd5
  } error_code_t;

  // Sample width, coded as bits[4:3] of the bit depth
  typedef enum logic [1:0] {
    WS_32 = 2'd0,
    WS_8  = 2'd1,
    WS_16 = 2'd2,
    WS_24 = 2'd3
  } width_sel_t;

  typedef struct packed {
    result_kind_t       kind;
    error_code_t        error_code;
    logic signed [31:0] sample_value;
    logic signed [31:0] normalized_value;
    logic [15:0]        channel_index;
    logic [31:0]        frame_index;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [15:0]        sample_bits;
    logic [31:0]        data_bytes;
    logic [31:0]        frame_count;
    logic               end_of_run;
  } res_t;

  typedef struct packed {
    res_t       res;
    width_sel_t wsel;
  } raw_t;

  typedef struct packed {
    logic [1:0] count;
    raw_t       first;
    raw_t       second;
  } pair_t;

  // Q2.30 of v / (2^(n-1) - 1), truncated toward zero.
  // Divide by 2^m - 1 as a geometric series of shifts plus a fold:
  // floor(x / (2^m - 1)) = (x + (x >> m) + 1) >> m for the x ranges used here.
  function automatic logic signed [31:0] scale_q230(input logic signed [31:0] v,
                                                    input width_sel_t w);
    logic [31:0] mag32;
    logic [33:0] mag;
    logic [33:0] x;
    logic [33:0] fold;
    logic [33:0] q;
    logic [31:0] q32;
    mag32 = v[31] ? (~v + 32'd1) : v;
    mag   = {2'b00, mag32};
    case (w)
      WS_8: begin
        x    = mag << 2;
        fold = (x + (x >> 7) + 34'd1) >> 7;
        q    = (mag << 23) + (mag << 16) + (mag << 9) + (mag << 2) + fold;
      end
      WS_16: begin
        x    = mag;
        fold = (x + (x >> 15) + 34'd1) >> 15;
        q    = (mag << 15) + mag + fold;
      end
      WS_24: begin
        x    = mag << 7;
        fold = (x + (x >> 23) + 34'd1) >> 23;
        q    = (mag << 7) + fold;
      end
      default: begin
        x    = (mag >> 1) + (mag[0] ? 34'h0_4000_0000 : 34'd0);
        fold = (x + (x >> 31) + 34'd1) >> 31;
        q    = (mag >> 1) + fold;
      end
    endcase
    q32 = q[31:0];
    return v[31] ? signed'(~q32 + 32'd1) : signed'(q32);
  endfunction

endpackage

// File: rtl/wpp_if.sv
interface wpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wpp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [2:0]         error_code;
  logic signed [31:0] sample_value;
  logic signed [31:0] normalized_value;
  logic [15:0]        channel_index;
  logic [31:0]        frame_index;
  logic [15:0]        channel_count;
  logic [31:0]        rate_hz;
  logic [15:0]        sample_bits;
  logic [31:0]        data_bytes;
  logic [31:0]        frame_count;
  logic               end_of_run;

  modport source (
    output valid, input ready,
    output result_kind, output error_code, output sample_value, output normalized_value,
    output channel_index, output frame_index, output channel_count, output rate_hz,
    output sample_bits, output data_bytes, output frame_count, output end_of_run
  );
  modport sink (
    input valid, output ready,
    input result_kind, input error_code, input sample_value, input normalized_value,
    input channel_index, input frame_index, input channel_count, input rate_hz,
    input sample_bits, input data_bytes, input frame_count, input end_of_run
  );
endinterface

// File: rtl/wpp_parser.sv
module wpp_parser import wpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output pair_t      pair
);

  logic [5:0]  header_position, header_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] bits_seen, bits_seen_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] sample_shift, sample_shift_next;
  logic [1:0]  byte_in_sample, byte_in_sample_next;
  logic [15:0] channel_counter, channel_counter_next;
  logic [31:0] frame_counter, frame_counter_next;
  logic        failed, failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      field_shift     <= '0;
      channels_seen   <= '0;
      rate_seen       <= '0;
      bits_seen       <= '0;
      bytes_left      <= '0;
      sample_shift    <= '0;
      byte_in_sample  <= '0;
      channel_counter <= '0;
      frame_counter   <= '0;
      failed          <= 1'b0;
    end else if (take) begin
      header_position <= header_position_next;
      field_shift     <= field_shift_next;
      channels_seen   <= channels_seen_next;
      rate_seen       <= rate_seen_next;
      bits_seen       <= bits_seen_next;
      bytes_left      <= bytes_left_next;
      sample_shift    <= sample_shift_next;
      byte_in_sample  <= byte_in_sample_next;
      channel_counter <= channel_counter_next;
      frame_counter   <= frame_counter_next;
      failed          <= failed_next;
    end
  end

  always_comb begin
    logic [31:0] shifted_field;
    logic [15:0] top16;
    logic        tag_error;
    error_code_t tag_code;
    logic [2:0]  sample_bytes;
    logic [31:0] gathered;
    logic [31:0] sample_int;
    logic [15:0] channel_inc;
    logic [1:0]  n;
    raw_t        rows [2];

    header_position_next = header_position;
    field_shift_next     = field_shift;
    channels_seen_next   = channels_seen;
    rate_seen_next       = rate_seen;
    bits_seen_next       = bits_seen;
    bytes_left_next      = bytes_left;
    sample_shift_next    = sample_shift;
    byte_in_sample_next  = byte_in_sample;
    channel_counter_next = channel_counter;
    frame_counter_next   = frame_counter;
    failed_next          = failed;

    n       = '0;
    rows[0] = '0;
    rows[1] = '0;

    shifted_field = {file_byte, field_shift[31:8]};
    top16         = shifted_field[31:16];
    tag_error     = 1'b0;
    tag_code      = ERR_RIFF;
    sample_bytes  = bits_seen[5:3];
    gathered      = sample_shift | ({24'd0, file_byte} << {byte_in_sample, 3'b000});
    sample_int    = gathered;
    channel_inc   = channel_counter + 16'd1;

    if (!failed) begin
      if (header_position < 6'(HEADER_LEN)) begin
        field_shift_next = shifted_field;
        case (header_position)
          POS_RIFF: begin
            if (shifted_field != TAG_RIFF) begin
              tag_error = 1'b1;
              tag_code  = ERR_RIFF;
            end
          end
          POS_WAVE: begin
            if (shifted_field != TAG_WAVE) begin
              tag_error = 1'b1;
              tag_code  = ERR_WAVE;
            end
          end
          POS_FMT: begin
            if (shifted_field != TAG_FMT) begin
              tag_error = 1'b1;
              tag_code  = ERR_FMT;
            end
          end
          POS_FORMAT: begin
            if (top16 != PCM_FORMAT) begin
              tag_error = 1'b1;
              tag_code  = ERR_FORMAT;
            end
          end
          POS_CHANNELS: channels_seen_next = top16;
          POS_RATE:     rate_seen_next = shifted_field;
          POS_BITS: begin
            bits_seen_next = top16;
            if ((top16 != DEPTH_8 && top16 != DEPTH_16 && top16 != DEPTH_24 &&
                 top16 != DEPTH_32) || channels_seen == '0) begin
              tag_error = 1'b1;
              tag_code  = ERR_FORMAT;
            end
          end
          POS_DATA: begin
            if (shifted_field != TAG_DATA) begin
              tag_error = 1'b1;
              tag_code  = ERR_DATA;
            end
          end
          default: ;
        endcase

        if (tag_error) begin
          rows[n[0]].res.kind       = KIND_ERROR;
          rows[n[0]].res.error_code = tag_code;
          n           = n + 2'd1;
          failed_next = 1'b1;
        end else begin
          header_position_next = header_position + 6'd1;
          if (header_position == POS_SIZE) begin
            bytes_left_next                = shifted_field;
            rows[n[0]].res.kind            = KIND_HEADER;
            rows[n[0]].res.channel_count   = channels_seen;
            rows[n[0]].res.rate_hz         = rate_seen;
            rows[n[0]].res.sample_bits     = bits_seen;
            rows[n[0]].res.data_bytes      = shifted_field;
            n = n + 2'd1;
          end
        end
      end else if (bytes_left != '0) begin
        bytes_left_next = bytes_left - 32'd1;
        if ({1'b0, byte_in_sample} + 3'd1 < sample_bytes) begin
          byte_in_sample_next = byte_in_sample + 2'd1;
          sample_shift_next   = gathered;
        end else begin
          // 8-bit PCM is offset binary; wider depths are two's complement
          case (width_sel_t'(bits_seen[4:3]))
            WS_8:    sample_int = {{24{~gathered[7]}}, ~gathered[7], gathered[6:0]};
            WS_16:   sample_int = {{16{gathered[15]}}, gathered[15:0]};
            WS_24:   sample_int = {{8{gathered[23]}}, gathered[23:0]};
            default: sample_int = gathered;
          endcase
          rows[n[0]].res.kind          = KIND_SAMPLE;
          rows[n[0]].res.sample_value  = signed'(sample_int);
          rows[n[0]].res.channel_index = channel_counter;
          rows[n[0]].res.frame_index   = frame_counter;
          rows[n[0]].wsel              = width_sel_t'(bits_seen[4:3]);
          n = n + 2'd1;
          sample_shift_next   = '0;
          byte_in_sample_next = '0;
          if (channel_inc == channels_seen) begin
            channel_counter_next = '0;
            frame_counter_next   = frame_counter + 32'd1;
          end else begin
            channel_counter_next = channel_inc;
          end
        end
      end

      if (end_of_file && !failed_next) begin
        if (header_position_next < 6'(HEADER_LEN) || bytes_left_next != '0 ||
            byte_in_sample_next != '0) begin
          rows[n[0]].res.kind       = KIND_ERROR;
          rows[n[0]].res.error_code = ERR_INCOMPLETE;
          failed_next = 1'b1;
        end else begin
          rows[n[0]].res.kind        = KIND_DONE;
          rows[n[0]].res.frame_count = frame_counter_next;
        end
        n = n + 2'd1;
      end
    end

    if (n != '0) begin
      rows[n[1]].res.end_of_run = 1'b1;
    end

    // end of file: the next byte opens a new file
    if (end_of_file) begin
      header_position_next = '0;
      field_shift_next     = '0;
      channels_seen_next   = '0;
      rate_seen_next       = '0;
      bits_seen_next       = '0;
      bytes_left_next      = '0;
      sample_shift_next    = '0;
      byte_in_sample_next  = '0;
      channel_counter_next = '0;
      frame_counter_next   = '0;
      failed_next          = 1'b0;
    end

    pair.count  = take ? n : 2'd0;
    pair.first  = rows[0];
    pair.second = rows[1];
  end

endmodule

// File: rtl/wpp_scaler.sv
module wpp_scaler import wpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pair_t      pair_in,
  output logic [1:0] held,
  output res_t       first,
  output res_t       second
);

  raw_t stage_first;
  raw_t stage_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= pair_in.count;
    end
  end

  always_ff @(posedge clk) begin
    stage_first  <= pair_in.first;
    stage_second <= pair_in.second;
  end

  always_comb begin
    first  = stage_first.res;
    second = stage_second.res;
    if (stage_first.res.kind == KIND_SAMPLE) begin
      first.normalized_value = scale_q230(stage_first.res.sample_value, stage_first.wsel);
    end
    if (stage_second.res.kind == KIND_SAMPLE) begin
      second.normalized_value = scale_q230(stage_second.res.sample_value,
                                           stage_second.wsel);
    end
  end

endmodule

// File: rtl/wpp_result_fifo.sv
module wpp_result_fifo import wpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  res_t                  push_first,
  input  res_t                  push_second,
  output logic [FIFO_CNT_W-1:0] level,
  output logic                  head_valid,
  input  logic                  head_taken,
  output res_t                  head
);

  res_t                  store [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign head_valid = (level != '0);
  assign pop        = head_valid && head_taken;
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      level  <= level + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      store[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      store[wr_ptr + FIFO_PTR_W'(1)] <= push_second;
    end
  end

endmodule

// File: rtl/wav_pcm_stream_parser_core.sv
// WAV PCM stream parser.
// wav_bytes: one byte of a WAV file per transaction, in file order, with
// end_of_file set on the last byte. The fixed 44-byte RIFF/WAVE/fmt/data
// header is checked (PCM only, 8/16/24/32-bit, non-zero channels).
// results: header info after the last header byte, then one sample per
// completed sample with channel/frame index and a Q2.30 value of
// sample / (2^(bits-1) - 1), then done (with frame count) or an error at
// end of file. end_of_run marks the last result caused by a byte; a byte
// gives at most two results. After an error, bytes are dropped until
// end of file. Data after the data chunk is ignored.
// Results are formed from each byte as it is taken, registered in the one
// stage of scaling, then written to the four-entry result queue and offered.
// Throughput: one byte per cycle while wav_bytes.ready is high; a byte
// that causes two results gives two output transactions.
// Reset: all parser state clears, queue empties; the next byte starts a file.
// Stall: while results are back-pressured the queue fills and wav_bytes.ready
// drops once too few free entries remain for a worst-case byte.
module wav_pcm_stream_parser_core import wpp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  wpp_byte_if.sink            wav_bytes,
  wpp_result_if.source        results
);

  logic                  take;
  pair_t                 parsed;
  logic [1:0]            staged;
  res_t                  scaled_first;
  res_t                  scaled_second;
  logic [FIFO_CNT_W-1:0] level;
  logic [FIFO_CNT_W:0]   load;
  logic                  head_valid;
  res_t                  head;

  // Space check: results still in the scaling stage plus a worst-case byte
  assign load            = {1'b0, level} + (FIFO_CNT_W + 1)'(staged);
  assign wav_bytes.ready = (load <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2));
  assign take            = wav_bytes.valid && wav_bytes.ready;

  wpp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .file_byte   (wav_bytes.file_byte),
    .end_of_file (wav_bytes.end_of_file),
    .pair        (parsed)
  );

  wpp_scaler u_scaler (
    .clk     (clk),
    .rst     (rst),
    .pair_in (parsed),
    .held    (staged),
    .first   (scaled_first),
    .second  (scaled_second)
  );

  wpp_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (staged),
    .push_first  (scaled_first),
    .push_second (scaled_second),
    .level       (level),
    .head_valid  (head_valid),
    .head_taken  (results.ready),
    .head        (head)
  );

  // Output transaction straight from the queue head register
  assign results.valid            = head_valid;
  assign results.result_kind      = head.kind;
  assign results.error_code       = head.error_code;
  assign results.sample_value     = head.sample_value;
  assign results.normalized_value = head.normalized_value;
  assign results.channel_index    = head.channel_index;
  assign results.frame_index      = head.frame_index;
  assign results.channel_count    = head.channel_count;
  assign results.rate_hz          = head.rate_hz;
  assign results.sample_bits      = head.sample_bits;
  assign results.data_bytes       = head.data_bytes;
  assign results.frame_count      = head.frame_count;
  assign results.end_of_run       = head.end_of_run;

endmodule
